/* hdl/cbk_pkg.sv */
// ----------------------------------------------------------------------------
// cbk_pkg
// Shared types and constants of the button chord key event generator:
// event codes, event slot positions, the configuration bundle, the record
// passed from the classifying front end to the emitting back end, and the
// queue status bundle.
// ----------------------------------------------------------------------------
package cbk_pkg;

  // Counter and register width.
  localparam int CntW = 16;

  // Event codes on the result channel.
  localparam logic [2:0] EV_TICK = 3'd0;
  localparam logic [2:0] EV_UP   = 3'd1;
  localparam logic [2:0] EV_DOWN = 3'd2;
  localparam logic [2:0] EV_OK   = 3'd3;
  localparam logic [2:0] EV_BACK = 3'd4;
  localparam logic [2:0] EV_AUTO = 3'd5;
  localparam logic [2:0] EV_FAST = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] REG_HOLD_DELAY   = 2'd0;
  localparam logic [1:0] REG_BACK_OFF     = 2'd1;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CntW-1:0] HOLD_DELAY_RST   = 16'd250;
  localparam logic [CntW-1:0] BACK_OFF_RST     = 16'd11;
  localparam logic [CntW-1:0] IDLE_TIMEOUT_RST = 16'd10000;

  // Event slots of one tick, in emission order.
  localparam int NumSlots  = 5;
  localparam int SLOT_UP   = 0;
  localparam int SLOT_DN   = 1;
  localparam int SLOT_AU   = 2;
  localparam int SLOT_IDLE = 3;
  localparam int SLOT_TICK = 4;

  // Configuration register bundle.
  typedef struct packed {
    logic [CntW-1:0] hold_delay;
    logic [CntW-1:0] back_off;
    logic [CntW-1:0] idle_timeout;
  } cfg_t;

  // One classified tick: pending event mask plus the codes of the key slots.
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [2:0]          up_code;
    logic [2:0]          dn_code;
    logic [2:0]          au_code;
  } evt_rec_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/cbk_front.sv */
// ----------------------------------------------------------------------------
// cbk_front
// Front end: accepts one tick transaction, updates the button flags, hold
// counters and idle counter, and pushes the tick's event record to the queue.
// ----------------------------------------------------------------------------
module cbk_front import cbk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  logic     control_level,
  input  logic     up_ok_level,
  input  logic     down_key_level,
  input  logic     auto_key_level,
  input  q_status_t q_stat,
  output logic     q_push,
  output evt_rec_t q_wdata
);

  logic [1:0]           dir_flag_r, dir_flag_nxt;
  logic [CntW-1:0]      hold_cnt_r   [2];
  logic [CntW-1:0]      hold_cnt_nxt [2];
  logic                 auto_flag_r, auto_flag_nxt;
  logic [CntW-1:0]      idle_cnt_r, idle_cnt_nxt;

  logic [1:0]           dir_lvl;
  logic [1:0]           dir_ev;
  logic [1:0]           dir_chord;
  logic [CntW-1:0]      hold_inc [2];
  logic [CntW:0]        hold_diff [2];
  logic                 any_press;
  logic [CntW-1:0]      idle_inc;
  logic [CntW-1:0]      idle_mid;
  logic                 idle_hit;
  logic                 auto_ev;

  // A tick is taken whenever the queue has room.
  assign q_push = in_valid && !q_stat.full;

  assign dir_lvl = {down_key_level, up_ok_level};

  // Up and down lanes: hold counting, repeat and release events.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hold_inc[i]     = (hold_cnt_r[i] == '1) ? hold_cnt_r[i] : hold_cnt_r[i] + 1'b1;
      hold_diff[i]    = {1'b0, hold_inc[i]} - {1'b0, cfg.back_off};
      dir_ev[i]       = 1'b0;
      dir_chord[i]    = 1'b0;
      dir_flag_nxt[i] = dir_flag_r[i];
      hold_cnt_nxt[i] = hold_cnt_r[i];
      if (dir_lvl[i]) begin
        dir_flag_nxt[i] = 1'b1;
        hold_cnt_nxt[i] = hold_inc[i];
        if (!control_level && (hold_inc[i] >= cfg.hold_delay)) begin
          dir_ev[i] = 1'b1;
          // Saturate at zero when the back-off exceeds the count.
          hold_cnt_nxt[i] = (hold_diff[i][CntW] || hold_diff[i][CntW-1:0] == '0) ?
                            '0 : hold_diff[i][CntW-1:0];
        end
      end else if (dir_flag_r[i]) begin
        dir_ev[i]       = 1'b1;
        dir_chord[i]    = control_level;
        dir_flag_nxt[i] = 1'b0;
        hold_cnt_nxt[i] = '0;
      end
    end
  end

  // Auto/fast key and idle timeout.
  always_comb begin
    any_press     = control_level | up_ok_level | down_key_level | auto_key_level;
    idle_inc      = (idle_cnt_r == '1) ? idle_cnt_r : idle_cnt_r + 1'b1;
    idle_mid      = any_press ? '0 : idle_inc;
    idle_hit      = (idle_mid >= cfg.idle_timeout);
    idle_cnt_nxt  = idle_hit ? '0 : idle_mid;
    auto_ev       = !auto_key_level && auto_flag_r;
    auto_flag_nxt = auto_key_level;
  end

  // Event record for the back end.
  always_comb begin
    q_wdata                    = '0;
    q_wdata.mask[SLOT_UP]      = dir_ev[0];
    q_wdata.mask[SLOT_DN]      = dir_ev[1];
    q_wdata.mask[SLOT_AU]      = auto_ev;
    q_wdata.mask[SLOT_IDLE]    = idle_hit;
    q_wdata.mask[SLOT_TICK]    = 1'b1;
    q_wdata.up_code            = dir_chord[0] ? EV_OK : EV_UP;
    q_wdata.dn_code            = dir_chord[1] ? EV_BACK : EV_DOWN;
    q_wdata.au_code            = control_level ? EV_FAST : EV_AUTO;
  end

  // Key state registers, updated once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_flag_r    <= '0;
      hold_cnt_r[0] <= '0;
      hold_cnt_r[1] <= '0;
      auto_flag_r   <= 1'b0;
      idle_cnt_r    <= '0;
    end else if (q_push) begin
      dir_flag_r    <= dir_flag_nxt;
      hold_cnt_r[0] <= hold_cnt_nxt[0];
      hold_cnt_r[1] <= hold_cnt_nxt[1];
      auto_flag_r   <= auto_flag_nxt;
      idle_cnt_r    <= idle_cnt_nxt;
    end
  end

endmodule

/* hdl/cbk_queue.sv */
// ----------------------------------------------------------------------------
// cbk_queue
// Two-entry queue of tick event records between the front and back ends.
// ----------------------------------------------------------------------------
module cbk_queue import cbk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  evt_rec_t  wdata,
  input  logic      pop,
  output evt_rec_t  rdata,
  output q_status_t stat
);

  evt_rec_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hdl/cbk_back.sv */
// ----------------------------------------------------------------------------
// cbk_back
// Back end: walks the pending events of each tick record in order and drives
// one event per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module cbk_back import cbk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  evt_rec_t  q_rdata,
  input  q_status_t q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [2:0] out_event_code,
  output logic      out_last_of_tick
);

  evt_rec_t   cur_r, cur_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] code_r, code_nxt;
  logic       last_r, last_nxt;

  logic       use_head;
  evt_rec_t   src;
  logic       src_ok;
  logic       advance;
  logic [2:0] sel_code;
  logic [NumSlots-1:0] sel_bit;

  assign out_valid        = out_valid_r;
  assign out_event_code   = code_r;
  assign out_last_of_tick = last_r;

  // Source is the record in progress, or the queue head once it is done.
  always_comb begin
    use_head = (cur_r.mask == '0);
    src      = use_head ? q_rdata : cur_r;
    src_ok   = !use_head || !q_stat.empty;
    advance  = !out_valid_r || !out_stall;
  end

  // Lowest pending slot goes out first.
  always_comb begin
    sel_bit  = '0;
    sel_code = EV_TICK;
    if (src.mask[SLOT_UP]) begin
      sel_bit[SLOT_UP] = 1'b1;
      sel_code         = src.up_code;
    end else if (src.mask[SLOT_DN]) begin
      sel_bit[SLOT_DN] = 1'b1;
      sel_code         = src.dn_code;
    end else if (src.mask[SLOT_AU]) begin
      sel_bit[SLOT_AU] = 1'b1;
      sel_code         = src.au_code;
    end else if (src.mask[SLOT_IDLE]) begin
      sel_bit[SLOT_IDLE] = 1'b1;
      sel_code           = EV_BACK;
    end else begin
      sel_bit[SLOT_TICK] = 1'b1;
      sel_code           = EV_TICK;
    end
  end

  // Output register load and record progress.
  always_comb begin
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (advance) begin
      out_valid_nxt = src_ok;
      if (src_ok) begin
        code_nxt     = sel_code;
        last_nxt     = sel_bit[SLOT_TICK];
        cur_nxt      = src;
        cur_nxt.mask = src.mask & ~sel_bit;
        q_pop        = use_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

endmodule

/* hdl/button_chord_key_event_generator_core.sv */
// ----------------------------------------------------------------------------
// button_chord_key_event_generator_core
// Turns 1 ms button level samples into key events with chord, auto-repeat
// and idle timeout handling.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------
//   in_     | in_valid/in_stall  | control, up_ok, down_key, auto_key levels
//   out_    | out_valid/out_stall| event_code, last_of_tick
//   cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick transaction is accepted in any cycle in which the two-entry queue
// has room; the front end classifies it in that same cycle.
// The back end emits one event per cycle unless out_stall holds it, so a tick
// yields 1 to 5 events, and the sustained rate is set by events per tick.
// Output stalls back up into the queue and then into in_stall.
// Synchronous reset clears key state, queue and output; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module button_chord_key_event_generator_core import cbk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_control_level,
  input  logic       in_up_ok_level,
  input  logic       in_down_key_level,
  input  logic       in_auto_key_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_code,
  output logic       out_last_of_tick,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_stat;
  logic      q_push;
  logic      q_pop;
  evt_rec_t  q_wdata;
  evt_rec_t  q_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_DELAY:   cfg_nxt.hold_delay   = cfg_data;
        REG_BACK_OFF:     cfg_nxt.back_off     = cfg_data;
        REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_delay   <= HOLD_DELAY_RST;
      cfg_r.back_off     <= BACK_OFF_RST;
      cfg_r.idle_timeout <= IDLE_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cbk_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .control_level   (in_control_level),
    .up_ok_level     (in_up_ok_level),
    .down_key_level  (in_down_key_level),
    .auto_key_level  (in_auto_key_level),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  cbk_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  cbk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rdata          (q_rdata),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_code   (out_event_code),
    .out_last_of_tick (out_last_of_tick)
  );

  // The final event of a tick is always the tick event.
  a_last_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_tick |-> out_event_code == EV_TICK)
    else $error("last event of a tick is not a tick event");

  // The back end never takes a record from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // The front end never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue pushed while full");

  // A stalled event stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_event_code) && $stable(out_last_of_tick))
    else $error("stalled event changed");

endmodule
